/* rtl/linear_recurrence_nth_term_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the linear recurrence block
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_RECURRENCE_NTH_TERM_DEFINES_SVH
`define LINEAR_RECURRENCE_NTH_TERM_DEFINES_SVH

// same-cycle implication
`define LRNT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LRNT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lrnt_pkg.sv */
// ----------------------------------------------------------------------------
// lrnt_pkg
// Shared widths, modulus constants and interface types.
// ----------------------------------------------------------------------------
package lrnt_pkg;

	localparam int VAL_W         = 27;
	localparam int ORDER_W       = 11;
	localparam int ENTRY_W       = 10;
	localparam int TARGET_W      = 63;
	localparam int RIDX_W        = 62;
	localparam int PROD_W        = 54;
	localparam int MU_W          = 28;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;
	localparam int MAX_ORDER_DEF = 1024;

	localparam logic [VAL_W-1:0] PRIME_M    = 27'd104857601;
	localparam logic [VAL_W-1:0] PRIME_M_M1 = 27'd104857600;
	localparam logic [MU_W-1:0]  BARRETT_MU = 28'd171798690;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_START = 1'b1;
	localparam logic ORDER_SEL = 1'b0;

	typedef struct packed {
		logic             valid;
		logic             neg;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
	} mm_in_t;

	typedef struct packed {
		logic             valid;
		logic             neg;
		logic [VAL_W-1:0] value;
	} mm_out_t;

	typedef struct packed {
		logic                load;
		logic                start;
		logic [ENTRY_W-1:0]  entry;
		logic [VAL_W-1:0]    term;
		logic [VAL_W-1:0]    coef;
		logic [TARGET_W-1:0] target;
	} core_cmd_t;

	typedef struct packed {
		logic             busy;
		logic             valid;
		logic [VAL_W-1:0] value;
	} core_res_t;

endpackage

/* rtl/linear_recurrence_nth_term.sv */
// ----------------------------------------------------------------------------
// linear_recurrence_nth_term
// N-th term of an order-k linear recurrence modulo 104857601.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): a transaction with action = load writes
// initial term a_i and coefficient c_(i+1) at entry_index; loads stream at one
// per cycle while the core is idle. A start transaction takes target_index and
// holds in_stall high until its result has been handed to the output register.
// A start runs about log2(n/k) halving rounds, each paced by the single
// multiply-reduce pipeline (one product per cycle while issuing, with a drain
// after each output coefficient). A start with n <= k skips the rounds,
// passes check, final and done, then shows its result on out_valid.
// Output channel (out_valid/out_stall): one term_value per start. The result
// sits in an output register; while the receiver stalls it holds, loads are
// still taken, and a further start waits at its end for the register to free.
// Reset clears the sequencer and sets order to 1; the leading denominator
// coefficient is fixed at M-1; term and coef memories are empty until loaded.
// Configuration: order at APB address 0; the user writes it only while idle (not enforced).
// ----------------------------------------------------------------------------
module linear_recurrence_nth_term #(
	parameter int MAX_ORDER = lrnt_pkg::MAX_ORDER_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic [lrnt_pkg::ENTRY_W-1:0]    entry_index,
	input  logic [lrnt_pkg::VAL_W-1:0]      initial_term,
	input  logic [lrnt_pkg::VAL_W-1:0]      coefficient,
	input  logic [lrnt_pkg::TARGET_W-1:0]   target_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lrnt_pkg::VAL_W-1:0]      term_value,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lrnt_pkg::PADDR_W-1:0]    paddr,
	input  logic [lrnt_pkg::PDATA_W-1:0]    pwdata,
	output logic [lrnt_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import lrnt_pkg::*;

	logic [ORDER_W-1:0] order_q;
	logic               out_valid_q;
	logic [VAL_W-1:0]   term_value_q;
	logic               in_accept, res_ready;
	core_cmd_t          cmd;
	core_res_t          res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ORDER_SEL) ? PDATA_W'(order_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_W'(1);
		end else if (psel && penable && pwrite && pready && paddr[2] == ORDER_SEL) begin
			order_q <= pwdata[ORDER_W-1:0];
		end
	end

	assign in_stall   = res.busy;
	assign in_accept  = in_valid && !res.busy;
	assign cmd.load   = in_accept && (action == ACT_LOAD);
	assign cmd.start  = in_accept && (action == ACT_START);
	assign cmd.entry  = entry_index;
	assign cmd.term   = initial_term;
	assign cmd.coef   = coefficient;
	assign cmd.target = target_index;

	assign res_ready = !out_valid_q || !out_stall;

	lrnt_core #(
		.MAX_ORDER (MAX_ORDER)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.order     (order_q),
		.cmd       (cmd),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			term_value_q <= res.value;
		end
	end

	assign out_valid  = out_valid_q;
	assign term_value = term_value_q;

endmodule

/* rtl/lrnt_mulmod.sv */
// ----------------------------------------------------------------------------
// lrnt_mulmod
// Four-stage modular multiplier: product, Barrett quotient, remainder, fix-up.
// ----------------------------------------------------------------------------
module lrnt_mulmod (
	input  logic             clk,
	input  logic             arst_n,
	input  lrnt_pkg::mm_in_t  mm_in,
	output lrnt_pkg::mm_out_t mm_out,
	output logic             busy
);
	import lrnt_pkg::*;

	localparam logic [VAL_W+1:0] TWO_M = {1'b0, PRIME_M, 1'b0};

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              n_s1, n_s2, n_s3, n_s4;
	logic [PROD_W-1:0] p_s1, p_s2;
	logic [MU_W-1:0]   q_s2;
	logic [VAL_W+1:0]  r_s3;
	logic [VAL_W-1:0]  val_s4;

	logic [2*MU_W-1:0] q_prod;
	logic [PROD_W:0]   qm_prod;
	logic [VAL_W+1:0]  r_c;
	logic [VAL_W-1:0]  fix_c;

	assign q_prod  = p_s1[PROD_W-1:PROD_W-MU_W] * BARRETT_MU;
	assign qm_prod = (PROD_W+1)'(q_s2) * (PROD_W+1)'(PRIME_M);
	assign r_c     = p_s2[VAL_W+1:0] - qm_prod[VAL_W+1:0];

	always_comb begin
		if (r_s3 >= TWO_M) begin
			fix_c = VAL_W'(r_s3 - TWO_M);
		end else if (r_s3 >= {2'b00, PRIME_M}) begin
			fix_c = VAL_W'(r_s3 - {2'b00, PRIME_M});
		end else begin
			fix_c = r_s3[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= mm_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		n_s1   <= mm_in.neg;
		p_s1   <= PROD_W'(mm_in.a) * PROD_W'(mm_in.b);
		n_s2   <= n_s1;
		p_s2   <= p_s1;
		q_s2   <= q_prod[2*MU_W-1:MU_W];
		n_s3   <= n_s2;
		r_s3   <= r_c;
		n_s4   <= n_s3;
		val_s4 <= fix_c;
	end

	assign mm_out.valid = v_s4;
	assign mm_out.neg   = n_s4;
	assign mm_out.value = val_s4;
	assign busy         = v_s1 | v_s2 | v_s3 | v_s4;

endmodule

/* rtl/lrnt_core.sv */
// ----------------------------------------------------------------------------
// lrnt_core
// Halving sequencer with term, denominator and scratch memories.
// ----------------------------------------------------------------------------
`include "linear_recurrence_nth_term_defines.svh"

module lrnt_core #(
	parameter int MAX_ORDER = lrnt_pkg::MAX_ORDER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lrnt_pkg::ORDER_W-1:0]  order,
	input  lrnt_pkg::core_cmd_t           cmd,
	input  logic                          res_ready,
	output lrnt_pkg::core_res_t           res
);
	import lrnt_pkg::*;

	localparam int DW     = $clog2(MAX_ORDER + 1);
	localparam int TW     = $clog2(2 * MAX_ORDER);
	localparam int SW     = TW + 1;
	localparam int CW     = (ORDER_W > DW) ? ORDER_W : DW;
	localparam int TDEPTH = 2 * MAX_ORDER;
	localparam int DDEPTH = MAX_ORDER + 1;

	typedef enum logic [10:0] {
		ST_IDLE       = 11'b000_0000_0001,
		ST_CHECK      = 11'b000_0000_0010,
		ST_EXT_ISSUE  = 11'b000_0000_0100,
		ST_EXT_DRAIN  = 11'b000_0000_1000,
		ST_EVEN_ISSUE = 11'b000_0001_0000,
		ST_EVEN_DRAIN = 11'b000_0010_0000,
		ST_COPY       = 11'b000_0100_0000,
		ST_FILT       = 11'b000_1000_0000,
		ST_HALVE      = 11'b001_0000_0000,
		ST_FINAL      = 11'b010_0000_0000,
		ST_DONE       = 11'b100_0000_0000
	} state_t;

	function automatic logic [VAL_W-1:0] reduce_in(input logic [VAL_W-1:0] x);
		reduce_in = (x >= PRIME_M) ? (x - PRIME_M) : x;
	endfunction

	state_t            state_q;
	logic [DW-1:0]     k_q;
	logic [RIDX_W-1:0] ridx_q;
	logic [TW-1:0]     i_q;
	logic [DW-1:0]     j_q, jhi_q;
	logic [VAL_W-1:0]  acc_q, res_q;
	logic              issue_v_q, issue_neg_q, issue_ext_q;
	logic              filt_wr_q, copy_wr_q;
	logic [TW-1:0]     filt_addr_q;
	logic [DW-1:0]     copy_addr_q;

	logic [VAL_W-1:0] term_mem [TDEPTH];
	logic [VAL_W-1:0] den_mem  [DDEPTH];
	logic [VAL_W-1:0] scr_mem  [DDEPTH];
	logic [VAL_W-1:0] term_rd_q, den_a_rd_q, den_b_rd_q, scr_rd_q;
	logic             den_a_zero_q, den_b_zero_q;

	logic             term_we, den_we, scr_we;
	logic [TW-1:0]    term_wa, term_ra;
	logic [VAL_W-1:0] term_wd, den_wd, scr_wd;
	logic [DW-1:0]    den_wa, den_ra_a, den_ra_b;

	logic [CW-1:0]    order_ext;
	logic [DW-1:0]    k_eff;
	logic [SW-1:0]    k_s, i_s, j_s, two_i, two_nx, lo_nx, hi_nx;
	logic [VAL_W-1:0] den_a_val, den_b_val, acc_add, acc_sub, acc_neg;
	logic [VAL_W:0]   add_raw;
	logic             pipe_busy, mm_busy, load_ok;
	mm_in_t           mm_in;
	mm_out_t          mm_out;

	assign order_ext = CW'(order);
	always_comb begin
		if (order_ext == '0) begin
			k_eff = DW'(1);
		end else if (order_ext > CW'(MAX_ORDER)) begin
			k_eff = DW'(MAX_ORDER);
		end else begin
			k_eff = DW'(order_ext);
		end
	end

	assign k_s    = SW'(k_q);
	assign i_s    = SW'(i_q);
	assign j_s    = SW'(j_q);
	assign two_i  = i_s << 1;
	assign two_nx = (i_s + SW'(1)) << 1;
	assign lo_nx  = (two_nx > k_s) ? (two_nx - k_s) : '0;
	assign hi_nx  = (two_nx > k_s) ? k_s : two_nx;

	assign pipe_busy = issue_v_q | mm_busy;
	assign load_ok   = cmd.load && (int'(cmd.entry) < MAX_ORDER);

	assign den_a_val = den_a_zero_q ? PRIME_M_M1 : den_a_rd_q;
	assign den_b_val = den_b_zero_q ? PRIME_M_M1 : den_b_rd_q;

	assign add_raw = {1'b0, acc_q} + {1'b0, mm_out.value};
	assign acc_add = (add_raw >= {1'b0, PRIME_M}) ? VAL_W'(add_raw - {1'b0, PRIME_M})
		: add_raw[VAL_W-1:0];
	assign acc_sub = (acc_q >= mm_out.value) ? (acc_q - mm_out.value)
		: (acc_q + (PRIME_M - mm_out.value));
	assign acc_neg = (acc_q == '0) ? '0 : (PRIME_M - acc_q);

	always_comb begin
		term_we = 1'b0;
		term_wa = TW'(cmd.entry);
		term_wd = reduce_in(cmd.term);
		term_ra = ridx_q[TW-1:0];
		if (load_ok) begin
			term_we = 1'b1;
		end else if (state_q == ST_EXT_DRAIN && !pipe_busy) begin
			term_we = 1'b1;
			term_wa = TW'(i_s + k_s);
			term_wd = acc_q;
		end else if (filt_wr_q) begin
			term_we = 1'b1;
			term_wa = filt_addr_q;
			term_wd = term_rd_q;
		end
		case (state_q)
			ST_EXT_ISSUE: term_ra = TW'(i_s + k_s - j_s);
			ST_FILT:      term_ra = i_q;
			default:      term_ra = ridx_q[TW-1:0];
		endcase
	end

	always_comb begin
		den_we   = load_ok | copy_wr_q;
		den_wa   = load_ok ? DW'({1'b0, cmd.entry} + (ENTRY_W+1)'(1)) : copy_addr_q;
		den_wd   = load_ok ? reduce_in(cmd.coef) : scr_rd_q;
		den_ra_a = j_q;
		den_ra_b = DW'(two_i - j_s);
		scr_we   = (state_q == ST_EVEN_DRAIN) && !pipe_busy;
		scr_wd   = acc_neg;
	end

	always_ff @(posedge clk) begin
		if (term_we) begin
			term_mem[term_wa] <= term_wd;
		end
		term_rd_q <= term_mem[term_ra];
	end

	always_ff @(posedge clk) begin
		if (den_we) begin
			den_mem[den_wa] <= den_wd;
		end
		den_a_rd_q   <= den_mem[den_ra_a];
		den_b_rd_q   <= den_mem[den_ra_b];
		den_a_zero_q <= (den_ra_a == '0);
		den_b_zero_q <= (den_ra_b == '0);
	end

	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_mem[DW'(i_q)] <= scr_wd;
		end
		scr_rd_q <= scr_mem[DW'(i_q)];
	end

	assign mm_in.valid = issue_v_q;
	assign mm_in.neg   = issue_neg_q;
	assign mm_in.a     = den_a_val;
	assign mm_in.b     = issue_ext_q ? term_rd_q : den_b_val;

	lrnt_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.mm_in  (mm_in),
		.mm_out (mm_out),
		.busy   (mm_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= DW'(1);
			ridx_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			jhi_q       <= '0;
			acc_q       <= '0;
			res_q       <= '0;
			issue_v_q   <= 1'b0;
			issue_neg_q <= 1'b0;
			issue_ext_q <= 1'b0;
			filt_wr_q   <= 1'b0;
			filt_addr_q <= '0;
			copy_wr_q   <= 1'b0;
			copy_addr_q <= '0;
		end else begin
			issue_v_q   <= (state_q == ST_EXT_ISSUE) || (state_q == ST_EVEN_ISSUE);
			issue_neg_q <= (state_q == ST_EVEN_ISSUE) && j_q[0];
			issue_ext_q <= (state_q == ST_EXT_ISSUE);
			filt_wr_q   <= (state_q == ST_FILT) && (i_q[0] == ridx_q[0]);
			filt_addr_q <= i_q >> 1;
			copy_wr_q   <= (state_q == ST_COPY);
			copy_addr_q <= DW'(i_q);
			if (mm_out.valid) begin
				acc_q <= mm_out.neg ? acc_sub : acc_add;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						k_q     <= k_eff;
						ridx_q  <= RIDX_W'(cmd.target - TARGET_W'(1));
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (ridx_q >= RIDX_W'(k_q)) begin
						i_q     <= '0;
						j_q     <= DW'(1);
						acc_q   <= '0;
						state_q <= ST_EXT_ISSUE;
					end else begin
						state_q <= ST_FINAL;
					end
				end
				ST_EXT_ISSUE: begin
					if (j_q == k_q) begin
						state_q <= ST_EXT_DRAIN;
					end else begin
						j_q <= j_q + DW'(1);
					end
				end
				ST_EXT_DRAIN: begin
					if (!pipe_busy) begin
						acc_q <= '0;
						if (i_s == k_s - SW'(1)) begin
							i_q     <= '0;
							j_q     <= '0;
							jhi_q   <= '0;
							state_q <= ST_EVEN_ISSUE;
						end else begin
							i_q     <= i_q + TW'(1);
							j_q     <= DW'(1);
							state_q <= ST_EXT_ISSUE;
						end
					end
				end
				ST_EVEN_ISSUE: begin
					if (j_q == jhi_q) begin
						state_q <= ST_EVEN_DRAIN;
					end else begin
						j_q <= j_q + DW'(1);
					end
				end
				ST_EVEN_DRAIN: begin
					if (!pipe_busy) begin
						acc_q <= '0;
						if (i_s == k_s) begin
							i_q     <= '0;
							state_q <= ST_COPY;
						end else begin
							i_q     <= i_q + TW'(1);
							j_q     <= DW'(lo_nx);
							jhi_q   <= DW'(hi_nx);
							state_q <= ST_EVEN_ISSUE;
						end
					end
				end
				ST_COPY: begin
					if (i_s == k_s) begin
						i_q     <= '0;
						state_q <= ST_FILT;
					end else begin
						i_q <= i_q + TW'(1);
					end
				end
				ST_FILT: begin
					if (i_s == (k_s << 1) - SW'(1)) begin
						state_q <= ST_HALVE;
					end else begin
						i_q <= i_q + TW'(1);
					end
				end
				ST_HALVE: begin
					ridx_q  <= ridx_q >> 1;
					state_q <= ST_CHECK;
				end
				ST_FINAL: begin
					res_q   <= term_rd_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.busy  = (state_q != ST_IDLE);
	assign res.valid = (state_q == ST_DONE);
	assign res.value = res_q;

	`LRNT_ASSERT_IMPL(a_mm_canonical, mm_out.valid, mm_out.value < PRIME_M, "product out of range")
	`LRNT_ASSERT_IMPL(a_done_in_range, state_q == ST_DONE, ridx_q < RIDX_W'(k_q), "index not reduced")
	`LRNT_ASSERT_IMPL(a_filt_drained, state_q == ST_FILT, !mm_busy, "filter with pipeline busy")
	`LRNT_ASSERT_NEXT(a_halve_check, state_q == ST_HALVE, state_q == ST_CHECK, "halve not followed by check")

endmodule

/* bench/tb_linear_recurrence_nth_term.sv */
// ----------------------------------------------------------------------------
// tb_linear_recurrence_nth_term
// Loads recurrence terms and coefficients, writes the order over APB and
// starts term computations; an in-bench model of the halving scheme predicts
// each term_value, which is checked in order against the output channel.
// ----------------------------------------------------------------------------
module tb_linear_recurrence_nth_term;
	timeunit 1ns;
	timeprecision 1ps;
	import lrnt_pkg::*;

	localparam longint unsigned MOD      = 64'd104857601;
	localparam int              MAXK     = 1024;
	localparam logic [PADDR_W-1:0] ORDER_ADDR = '0;
	localparam longint unsigned IDX_MASK = (64'd1 << 62) - 1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                action = ACT_LOAD;
	logic [ENTRY_W-1:0]  entry_index = '0;
	logic [VAL_W-1:0]    initial_term = '0;
	logic [VAL_W-1:0]    coefficient = '0;
	logic [TARGET_W-1:0] target_index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [VAL_W-1:0]    term_value;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	longint unsigned terms[2*MAXK];
	longint unsigned den[MAXK+1];
	longint unsigned den_next[MAXK+1];
	int unsigned     order_reg = 1;
	logic [VAL_W-1:0] term_queue[$];
	int unsigned     send_idle_pct = 0;
	int unsigned     stall_pct = 0;
	int unsigned     errors = 0;

	linear_recurrence_nth_term i_dut (.*);

	always #5 clk = ~clk;

	function automatic int unsigned active_order();
		if (order_reg == 0) return 1;
		if (order_reg > MAXK) return MAXK;
		return order_reg;
	endfunction

	function automatic longint unsigned den_at(int unsigned j, int unsigned k);
		return (j <= k) ? den[j] : 64'd0;
	endfunction

	function automatic logic [VAL_W-1:0] nth_term(logic [TARGET_W-1:0] target);
		int unsigned k;
		int unsigned filt;
		longint unsigned t;
		longint unsigned p;
		longint unsigned n;
		k = active_order();
		n = (longint'(target) - 1) & IDX_MASK;
		while (n >= k) begin
			for (int i = 0; i < k; i++) begin
				t = 0;
				for (int j = 1; j <= k; j++)
					t = (t + den[j] * terms[i+k-j]) % MOD;
				terms[i+k] = t;
			end
			for (int i = 0; i <= k; i++) begin
				t = 0;
				for (int j = 0; j <= 2*i; j++) begin
					p = (den_at(j, k) * den_at(2*i-j, k)) % MOD;
					t = (j % 2) ? (t + MOD - p) % MOD : (t + p) % MOD;
				end
				den_next[i] = (MOD - t) % MOD;
			end
			for (int i = 0; i <= k; i++)
				den[i] = den_next[i];
			filt = 0;
			for (int i = 0; i < 2*k; i++) begin
				if ((n & 1) == (i & 1)) begin
					terms[filt] = terms[i];
					filt++;
				end
			end
			n = n >> 1;
		end
		return VAL_W'(terms[n] % MOD);
	endfunction

	task automatic report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Checker and receiver stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (term_queue.size() == 0)
				report("unexpected term_value", term_value, '0);
			else if (term_value !== term_queue[0]) begin
				report("term_value", term_value, term_queue[0]);
				void'(term_queue.pop_front());
			end else
				void'(term_queue.pop_front());
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send(logic act, int unsigned e, logic [VAL_W-1:0] a,
			logic [VAL_W-1:0] c, logic [TARGET_W-1:0] tgt);
		action       <= act;
		entry_index  <= e[ENTRY_W-1:0];
		initial_term <= a;
		coefficient  <= c;
		target_index <= tgt;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (act == ACT_LOAD) begin
			terms[e] = a % MOD;
			den[e+1] = c % MOD;
		end else
			term_queue.insert(term_queue.size(), nth_term(tgt));
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
	endtask

	task automatic load(int unsigned e, logic [VAL_W-1:0] a, logic [VAL_W-1:0] c);
		send(ACT_LOAD, e, a, c, TARGET_W'({$urandom, $urandom}));
	endtask

	task automatic start(logic [TARGET_W-1:0] tgt);
		send(ACT_START, $urandom_range(1023), VAL_W'($urandom), VAL_W'($urandom), tgt);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (term_queue.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_order(int unsigned value);
		drain();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ORDER_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		order_reg = value & 11'h7FF;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_all(int unsigned k);
		for (int i = 0; i < k; i++)
			load(i, VAL_W'($urandom_range(MOD - 1)), VAL_W'($urandom_range(MOD - 1)));
	endtask

	function automatic logic [TARGET_W-1:0] rand_target();
		case ($urandom_range(9))
			0: return TARGET_W'({$urandom, $urandom});
			1, 2: return TARGET_W'($urandom_range(40) + 1);
			default: return TARGET_W'($urandom_range(1_000_000) + 1);
		endcase
	endfunction

	task automatic test_directed();
		write_order(1);
		load(0, '1, '1);
		start(TARGET_W'(1));
		start(TARGET_W'(2));
		start('0);
		start({1'b1, 62'd0});
		write_order(3);
		load(0, '0, '0);
		load(1, VAL_W'(MOD - 1), VAL_W'(MOD - 1));
		load(2, VAL_W'(MOD), VAL_W'(MOD + 7));
		load(700, VAL_W'($urandom), VAL_W'($urandom));
		start(TARGET_W'(3));
		start(TARGET_W'(4));
		start(TARGET_W'(4));
		start('1);
		write_order(0);
		start(TARGET_W'(5));
	endtask

	task automatic test_extreme_order();
		write_order(2047);
		load(0, VAL_W'($urandom_range(MOD - 1)), VAL_W'($urandom_range(MOD - 1)));
		load(516, VAL_W'($urandom_range(MOD - 1)), VAL_W'($urandom_range(MOD - 1)));
		load(MAXK - 1, VAL_W'($urandom_range(MOD - 1)), VAL_W'($urandom_range(MOD - 1)));
		start(TARGET_W'(MAXK));
		start(TARGET_W'(1));
		write_order(MAXK);
		start(TARGET_W'(517));
		write_order(64);
		load_all(64);
		start(TARGET_W'(200));
	endtask

	task automatic test_random(int unsigned n_items);
		int unsigned sent;
		int unsigned k;
		sent = 0;
		while (sent < n_items) begin
			k = ($urandom_range(7) == 0) ? $urandom_range(32, 9) : $urandom_range(8, 1);
			write_order(k);
			load_all(k);
			sent += k;
			repeat ($urandom_range(3, 1)) begin
				if ($urandom_range(3) == 0) begin
					load($urandom_range(1023, k), VAL_W'($urandom), VAL_W'($urandom));
					sent++;
				end
				start(rand_target());
				sent++;
			end
			if ($urandom_range(4) == 0) begin
				load($urandom_range(k - 1), VAL_W'($urandom), VAL_W'($urandom));
				start(rand_target());
				sent += 2;
			end
		end
	endtask

	initial begin
		for (int i = 0; i <= MAXK; i++)
			den[i] = 0;
		den[0] = MOD - 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extreme_order();
		send_idle_pct = 0;  stall_pct = 0;  test_random(110);
		send_idle_pct = 76; stall_pct = 0;  test_random(110);
		send_idle_pct = 0;  stall_pct = 76; test_random(110);
		send_idle_pct = 12; stall_pct = 12; test_random(110);
		drain();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#400ms;
		$display("tb: failure");
		$finish;
	end

endmodule
